@@ hdl/joystick_sample_packet_framer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Joystick sample packet framer assertion macros
// Clocked property checks, compiled out when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_SAMPLE_PACKET_FRAMER_UNIT_DEFINES_SVH
`define JOYSTICK_SAMPLE_PACKET_FRAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked at every clock edge out of reset
`define JSPF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define JSPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JSPF_ASSERT_IMPL(lbl, ante, cons, msg)
`define JSPF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/jspf_pkg.sv @@
// ----------------------------------------------------------------------------
// Joystick sample packet framer package
// Packet layout constants, scaling constants and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package jspf_pkg;

  // packet layout
  localparam int unsigned PKT_LEN   = 18;
  localparam int unsigned SUM_LEN   = 16;
  localparam int unsigned SUM_POS   = 16;
  localparam logic [7:0]  PKT_SOF0  = 8'hA5;
  localparam logic [7:0]  PKT_SOF1  = 8'h5A;
  localparam logic [7:0]  PKT_PAD   = 8'h00;

  // scaling: value = raw * 10000 / 4095, division done as multiply by
  // ceil(2^38 / 4095) and shift right by 38 (exact for all 12-bit raws)
  localparam int unsigned RAW_W       = 12;
  localparam int unsigned PROD_W      = 26;
  localparam int unsigned VAL_W       = 14;
  localparam int unsigned RECIP_W     = 27;
  localparam int unsigned WIDE_W      = PROD_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [PROD_W-1:0]  SCALE_NUM = 26'd10000;
  localparam logic [RECIP_W-1:0] RECIP_M   = 27'd67125253;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_IDLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_IDLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION    = 3'd3;
  localparam int unsigned CFG_DATA_W = 16;

  // one byte position of the output chain
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } jspf_byte_t;

  // shift control shared by all chain cells
  typedef struct packed {
    logic advance;
    logic load;
  } jspf_shift_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/jspf_scale.sv @@
// ----------------------------------------------------------------------------
// Joystick sample scaling lane
// Two-stage constant multiply that turns a 12-bit reading into hundredths of
// a percent.
// ----------------------------------------------------------------------------
`default_nettype none

module jspf_scale (
  input  wire logic                       clk_i,
  input  wire logic                       s1_en_i,
  input  wire logic                       s2_en_i,
  input  wire logic [jspf_pkg::RAW_W-1:0] raw_i,
  output logic      [jspf_pkg::VAL_W-1:0] value_o
);
  import jspf_pkg::*;

  logic [PROD_W-1:0] prod_q;
  logic [WIDE_W-1:0] wide;
  logic [VAL_W-1:0]  value_q;

  // first stage: raw * 10000
  always_ff @(posedge clk_i) begin
    if (s1_en_i) begin
      prod_q <= PROD_W'(raw_i) * SCALE_NUM;
    end
  end

  // second stage: divide by 4095 through the reciprocal
  assign wide = WIDE_W'(prod_q) * WIDE_W'(RECIP_M);

  always_ff @(posedge clk_i) begin
    if (s2_en_i) begin
      value_q <= wide[RECIP_SHIFT +: VAL_W];
    end
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

@@ hdl/jspf_cell.sv @@
// ----------------------------------------------------------------------------
// Joystick packet chain cell
// Holds one packet byte; loads in parallel or takes its neighbor's byte.
// ----------------------------------------------------------------------------
`default_nettype none

module jspf_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire jspf_pkg::jspf_shift_ctrl_t ctrl_i,
  input  wire jspf_pkg::jspf_byte_t       load_i,
  input  wire jspf_pkg::jspf_byte_t       nbr_i,
  input  wire logic                       nbr_valid_i,
  output jspf_pkg::jspf_byte_t            byte_o,
  output logic                            valid_o
);
  import jspf_pkg::*;

  logic       valid_q;
  jspf_byte_t byte_q;

  // track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      valid_q <= 1'b1;
    end else if (ctrl_i.advance) begin
      valid_q <= nbr_valid_i;
    end
  end

  // load a fresh packet byte or shift from the neighbor
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      byte_q <= load_i;
    end else if (ctrl_i.advance) begin
      byte_q <= nbr_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

@@ hdl/joystick_sample_packet_framer_unit.sv @@
// ----------------------------------------------------------------------------
// Joystick sample packet framer
// Flow: a sample set is registered in stage 1, then stage 2, then loaded into
//   the 18-cell output byte chain; each step can stall. Throughput: one byte
//   per cycle when not stalled; the next packet loads as the pad byte leaves.
// Reset: asynchronous, clears sequence counter, stage and chain valid bits,
//   and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "joystick_sample_packet_framer_unit_defines.svh"

module joystick_sample_packet_framer_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration write channel
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [jspf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [jspf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // sample set channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [11:0]                          right_x_sample_i,
  input  wire logic [11:0]                          right_y_sample_i,
  input  wire logic [11:0]                          left_x_sample_i,
  input  wire logic [11:0]                          left_y_sample_i,
  input  wire logic                                 right_switch_level_i,
  input  wire logic                                 left_switch_level_i,
  input  wire logic [15:0]                          left_touch_reading_i,
  input  wire logic [15:0]                          right_touch_reading_i,
  // packet byte channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [7:0]                                wire_byte_o,
  output logic                                      last_byte_o
);
  import jspf_pkg::*;

  // configuration registers
  logic        right_idle_q;
  logic        left_idle_q;
  logic [15:0] touch_thr_q;
  logic [7:0]  version_q;

  logic        in_accept;
  logic [7:0]  seq_q;

  // stage 1 and stage 2 control and side data
  logic        s1_valid_q;
  logic        s1_move;
  logic [7:0]  s1_seq_q;
  logic [7:0]  s1_ver_q;
  logic [3:0]  s1_flags_q;
  logic        s2_valid_q;
  logic [7:0]  s2_seq_q;
  logic [7:0]  s2_ver_q;
  logic [3:0]  s2_flags_q;

  logic [RAW_W-1:0] raw [4];
  logic [VAL_W-1:0] val [4];

  logic [7:0]       pkt_b [PKT_LEN];
  logic [7:0]       csum;

  jspf_shift_ctrl_t ctrl;
  jspf_byte_t       cell_b [PKT_LEN];
  logic             cell_v [PKT_LEN];

  assign cfg_ready_o = 1'b1;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_idle_q <= 1'b1;
      left_idle_q  <= 1'b1;
      touch_thr_q  <= 16'd30;
      version_q    <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_RIGHT_IDLE: right_idle_q <= cfg_data_i[0];
        CFG_LEFT_IDLE:  left_idle_q  <= cfg_data_i[0];
        CFG_TOUCH_THR:  touch_thr_q  <= cfg_data_i[15:0];
        CFG_VERSION:    version_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // handshake and stage movement
  assign ctrl.advance = !cell_v[0] || !out_stall_i;
  assign ctrl.load    = s2_valid_q && ctrl.advance && !cell_v[1];
  assign s1_move      = s1_valid_q && (!s2_valid_q || ctrl.load);
  assign in_stall_o   = s1_valid_q && !s1_move;
  assign in_accept    = in_valid_i && !in_stall_o;

  // hold stage valid bits and the sequence counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q      <= 8'd0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        seq_q <= seq_q + 8'd1;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        s2_valid_q <= 1'b1;
      end else if (ctrl.load) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // capture header fields and flags with the transaction, then advance them
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_seq_q   <= seq_q;
      s1_ver_q   <= version_q;
      s1_flags_q <= {right_touch_reading_i < touch_thr_q,
                     left_touch_reading_i  < touch_thr_q,
                     left_switch_level_i  != left_idle_q,
                     right_switch_level_i != right_idle_q};
    end
    if (s1_move) begin
      s2_seq_q   <= s1_seq_q;
      s2_ver_q   <= s1_ver_q;
      s2_flags_q <= s1_flags_q;
    end
  end

  // scale the four stick readings
  assign raw[0] = right_x_sample_i;
  assign raw[1] = right_y_sample_i;
  assign raw[2] = left_x_sample_i;
  assign raw[3] = left_y_sample_i;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    jspf_scale u_scale (
      .clk_i   (clk_i),
      .s1_en_i (in_accept),
      .s2_en_i (s1_move),
      .raw_i   (raw[l]),
      .value_o (val[l])
    );
  end

  // assemble packet bytes
  always_comb begin
    pkt_b[0] = PKT_SOF0;
    pkt_b[1] = PKT_SOF1;
    pkt_b[2] = s2_ver_q;
    pkt_b[3] = s2_seq_q;
    for (int k = 0; k < 4; k++) begin
      pkt_b[4 + 2*k] = val[k][7:0];
      pkt_b[5 + 2*k] = 8'(val[k][VAL_W-1:8]);
    end
    for (int k = 0; k < 4; k++) begin
      pkt_b[12 + k] = 8'(s2_flags_q[k]);
    end
    csum = 8'd0;
    for (int k = 0; k < SUM_LEN; k++) begin
      csum = csum ^ pkt_b[k];
    end
    pkt_b[SUM_POS]     = csum;
    pkt_b[PKT_LEN - 1] = PKT_PAD;
  end

  // output byte chain; cell 0 drives the output port
  for (genvar c = 0; c < PKT_LEN; c++) begin : g_cell
    jspf_byte_t load_b;
    jspf_byte_t nbr_b;
    logic       nbr_v;

    assign load_b.data = pkt_b[c];
    assign load_b.last = (c == PKT_LEN - 1);

    if (c == PKT_LEN - 1) begin : g_tail
      assign nbr_b = '0;
      assign nbr_v = 1'b0;
    end else begin : g_body
      assign nbr_b = cell_b[c + 1];
      assign nbr_v = cell_v[c + 1];
    end

    jspf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .load_i      (load_b),
      .nbr_i       (nbr_b),
      .nbr_valid_i (nbr_v),
      .byte_o      (cell_b[c]),
      .valid_o     (cell_v[c])
    );
  end

  assign out_valid_o = cell_v[0];
  assign wire_byte_o = cell_b[0].data;
  assign last_byte_o = cell_b[0].last;

  // checks
  `JSPF_ASSERT_IMPL(a_last_ends_chain, out_valid_o && last_byte_o, !cell_v[1],
    "pad byte at output with more bytes queued behind it")
  `JSPF_ASSERT_IMPL(a_chain_packed, cell_v[PKT_LEN - 1], cell_v[0],
    "chain tail valid while output cell is empty")
  `JSPF_ASSERT_NEXT(a_seq_step, in_accept, seq_q == $past(seq_q) + 8'd1,
    "sequence counter did not step on a sample transaction")
  `JSPF_ASSERT_NEXT(a_packets_abut, out_valid_o && !out_stall_i && last_byte_o && s2_valid_q,
    out_valid_o && !last_byte_o, "queued packet did not follow the pad byte")

endmodule

`default_nettype wire
